/* src/amo_pkg.sv */
// ============================================================================
// amo_pkg - shared types and constants of the atomic memory operation unit
// Operation codes, data widths and the control structs between the top level
// and the operation datapath.
// ============================================================================
package amo_pkg;

    localparam int DATA_W            = 64;
    localparam int HALF_W            = 32;
    localparam int OP_W              = 4;
    localparam int DEFAULT_ADDR_BITS = 16;

    typedef enum logic [OP_W-1:0] {
        OP_LR   = 4'd0,
        OP_SC   = 4'd1,
        OP_SWAP = 4'd2,
        OP_ADD  = 4'd3,
        OP_XOR  = 4'd4,
        OP_AND  = 4'd5,
        OP_OR   = 4'd6,
        OP_MIN  = 4'd7,
        OP_MAX  = 4'd8,
        OP_MINU = 4'd9,
        OP_MAXU = 4'd10
    } t_op;

    // request state as seen by the datapath in the execute stage
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            is_double;
        logic            hi;          // word access to the upper half
        logic            misaligned;
        logic            sc_ok;       // reservation valid and matching
    } t_alu_ctrl;

    typedef struct packed {
        logic              wr_en;
        logic [DATA_W-1:0] wr_word;
        logic [DATA_W-1:0] result;
        logic              misaligned;
        logic              resv_set;    // LR taken
        logic              resv_clr;    // SC taken, pass or fail
    } t_alu_out;

    function automatic logic [DATA_W-1:0] sext32(input logic [HALF_W-1:0] v);
        return {{(DATA_W-HALF_W){v[HALF_W-1]}}, v};
    endfunction

endpackage

/* src/amo_if.sv */
// ============================================================================
// amo_if - request and response channels of the atomic memory operation unit
// Valid/ready channels; a request moves at an edge with valid and ready high.
// ============================================================================
interface amo_req_if #(
    parameter int ADDR_BITS = amo_pkg::DEFAULT_ADDR_BITS
) ();
    logic                        valid;
    logic                        ready;
    logic [amo_pkg::OP_W-1:0]    op;
    logic                        is_double;
    logic [ADDR_BITS-1:0]        addr;
    logic [amo_pkg::DATA_W-1:0]  src_value;

    modport source (output valid, output op, output is_double, output addr,
                    output src_value, input ready);
    modport sink   (input valid, input op, input is_double, input addr,
                    input src_value, output ready);
endinterface

interface amo_rsp_if ();
    logic                        valid;
    logic                        ready;
    logic [amo_pkg::DATA_W-1:0]  result_value;
    logic                        misaligned;

    modport source (output valid, output result_value, output misaligned,
                    input ready);
    modport sink   (input valid, input result_value, input misaligned,
                    output ready);
endinterface

/* src/amo_alu.sv */
// ============================================================================
// amo_alu - operation datapath of the atomic memory operation unit
// Extract the old value, apply the operation, merge the new value back into
// the 64-bit memory word and form the returned value.
// ============================================================================
module amo_alu (
    input  amo_pkg::t_alu_ctrl          i_ctrl,
    input  logic [amo_pkg::DATA_W-1:0]  i_src,
    input  logic [amo_pkg::DATA_W-1:0]  i_word,
    output amo_pkg::t_alu_out           o_out
);

    localparam int DW = amo_pkg::DATA_W;
    localparam int HW = amo_pkg::HALF_W;

    logic [HW-1:0] old_half;
    logic [DW-1:0] old_v;
    logic [DW-1:0] src_v;
    logic          lt_s;
    logic          lt_u;
    logic          known_op;
    logic          is_lr;
    logic          is_sc;
    logic [DW-1:0] new_v;

    always_comb begin
        old_half = i_ctrl.hi ? i_word[DW-1:HW] : i_word[HW-1:0];
        old_v    = i_ctrl.is_double ? i_word : amo_pkg::sext32(old_half);
        src_v    = i_ctrl.is_double ? i_src  : amo_pkg::sext32(i_src[HW-1:0]);
        lt_s     = $signed(old_v) < $signed(src_v);
        lt_u     = i_ctrl.is_double ? (old_v < src_v) : (old_v[HW-1:0] < src_v[HW-1:0]);
    end

    always_comb begin
        known_op = 1'b1;
        is_lr    = 1'b0;
        is_sc    = 1'b0;
        new_v    = src_v;
        case (i_ctrl.op)
            amo_pkg::OP_LR:   is_lr = 1'b1;
            amo_pkg::OP_SC:   is_sc = 1'b1;
            amo_pkg::OP_SWAP: new_v = src_v;
            amo_pkg::OP_ADD:  new_v = old_v + src_v;
            amo_pkg::OP_XOR:  new_v = old_v ^ src_v;
            amo_pkg::OP_AND:  new_v = old_v & src_v;
            amo_pkg::OP_OR:   new_v = old_v | src_v;
            amo_pkg::OP_MIN:  new_v = lt_s ? old_v : src_v;
            amo_pkg::OP_MAX:  new_v = lt_s ? src_v : old_v;
            amo_pkg::OP_MINU: new_v = lt_u ? old_v : src_v;
            amo_pkg::OP_MAXU: new_v = lt_u ? src_v : old_v;
            default:          known_op = 1'b0;
        endcase
    end

    always_comb begin
        o_out.misaligned = known_op & i_ctrl.misaligned;
        o_out.resv_set   = known_op & ~i_ctrl.misaligned & is_lr;
        o_out.resv_clr   = known_op & ~i_ctrl.misaligned & is_sc;
        o_out.wr_en      = known_op & ~i_ctrl.misaligned & ~is_lr
                           & (~is_sc | i_ctrl.sc_ok);

        // merge the new value into the word that was read
        if (i_ctrl.is_double) begin
            o_out.wr_word = new_v;
        end else if (i_ctrl.hi) begin
            o_out.wr_word = {new_v[HW-1:0], i_word[HW-1:0]};
        end else begin
            o_out.wr_word = {i_word[DW-1:HW], new_v[HW-1:0]};
        end

        if (!known_op || i_ctrl.misaligned) begin
            o_out.result = '0;
        end else if (is_sc) begin
            o_out.result = i_ctrl.sc_ok ? DW'(0) : DW'(1);
        end else begin
            o_out.result = old_v;
        end
    end

endmodule

/* src/atomic_memory_op_unit.sv */
// ============================================================================
// atomic_memory_op_unit - RISC-V LR/SC and AMO unit over a local data memory
// Flow: the memory read and the request are registered at request accept; execute
//   and the response register load follow when that register is free or being emptied.
// Only one request is in flight: the read-modify-write of the data memory holds
//   it between read and write, and no new request is taken until it has executed.
// A held response does not block: one more request is read while it waits.
// Reset: synchronous, active low; then a clearing pass writes zero to every
//   memory word (2**(ADDR_BITS-3) words, 8192 at default), requests held off.
// ============================================================================
module atomic_memory_op_unit #(
    parameter int ADDR_BITS = amo_pkg::DEFAULT_ADDR_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    amo_req_if.sink     i_req,
    amo_rsp_if.source   o_rsp
);

    localparam int DW     = amo_pkg::DATA_W;
    localparam int WIDX_W = ADDR_BITS - 3;
    localparam int DEPTH  = 1 << WIDX_W;

    // data memory, one 64-bit little-endian word per entry
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // clearing pass after reset
    logic              r_clearing;
    logic [WIDX_W-1:0] r_clr_idx;

    // request held between memory read and execute
    logic                     r_busy;
    logic [amo_pkg::OP_W-1:0] r_op;
    logic                     r_is_double;
    logic                     r_misaligned;
    logic [ADDR_BITS-1:0]     r_addr;
    logic [DW-1:0]            r_src;

    // reservation
    logic                 r_resv_valid;
    logic [ADDR_BITS-1:0] r_resv_addr;

    // response register
    logic          r_out_valid;
    logic [DW-1:0] r_out_value;
    logic          r_out_mis;

    logic               req_fire;
    logic               exec_fire;
    logic               req_mis;
    logic               mem_we;
    logic [WIDX_W-1:0]  mem_widx;
    logic [DW-1:0]      mem_wdata;
    amo_pkg::t_alu_ctrl alu_ctrl;
    amo_pkg::t_alu_out  alu_out;

    // take a request only with the memory cleared and the execute slot free
    assign i_req.ready = ~r_clearing & ~r_busy;
    assign req_fire    = i_req.valid & i_req.ready;
    // execute once the response register is free or being emptied
    assign exec_fire   = r_busy & (~r_out_valid | o_rsp.ready);

    assign req_mis = i_req.is_double ? (i_req.addr[2:0] != 3'd0)
                                     : (i_req.addr[1:0] != 2'd0);

    // ------------------------------------------------------------------
    // Clearing pass
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + WIDX_W'(1);
            if (&r_clr_idx) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Memory: one write port (clear or writeback), one registered read.
    // The read data holds until the next accepted request.
    // ------------------------------------------------------------------
    always_comb begin
        if (r_clearing) begin
            mem_we    = 1'b1;
            mem_widx  = r_clr_idx;
            mem_wdata = '0;
        end else begin
            mem_we    = exec_fire & alu_out.wr_en;
            mem_widx  = r_addr[ADDR_BITS-1:3];
            mem_wdata = alu_out.wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_widx] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_rd_data <= r_mem[i_req.addr[ADDR_BITS-1:3]];
        end
    end

    // ------------------------------------------------------------------
    // Request stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (req_fire) begin
            r_busy <= 1'b1;
        end else if (exec_fire) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_op         <= i_req.op;
            r_is_double  <= i_req.is_double;
            r_misaligned <= req_mis;
            r_addr       <= i_req.addr;
            r_src        <= i_req.src_value;
        end
    end

    // ------------------------------------------------------------------
    // Execute: operation datapath
    // ------------------------------------------------------------------
    always_comb begin
        alu_ctrl.op         = r_op;
        alu_ctrl.is_double  = r_is_double;
        alu_ctrl.hi         = r_addr[2];
        alu_ctrl.misaligned = r_misaligned;
        // SC compares the full byte address
        alu_ctrl.sc_ok      = r_resv_valid & (r_resv_addr == r_addr);
    end

    amo_alu u_alu (
        .i_ctrl (alu_ctrl),
        .i_src  (r_src),
        .i_word (r_rd_data),
        .o_out  (alu_out)
    );

    // reservation: an aligned LR sets it, an aligned SC drops it whether it passes or not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resv_valid <= 1'b0;
            r_resv_addr  <= '0;
        end else if (exec_fire) begin
            if (alu_out.resv_set) begin
                r_resv_valid <= 1'b1;
                r_resv_addr  <= r_addr;
            end else if (alu_out.resv_clr) begin
                r_resv_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out_value <= alu_out.result;
            r_out_mis   <= alu_out.misaligned;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_value;
    assign o_rsp.misaligned   = r_out_mis;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_exec_in_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_clearing)
        else $error("request in flight during clearing pass");

    a_accept_loads_stage : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> r_busy)
        else $error("accepted request not held for execute");

    a_misaligned_no_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_fire && alu_out.misaligned) |-> (!alu_out.wr_en && !alu_out.resv_set))
        else $error("misaligned request changed state");

    a_sc_clears_resv : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_fire && r_op == amo_pkg::OP_SC && !r_misaligned) |=> !r_resv_valid)
        else $error("SC left the reservation set");

    a_exec_fills_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire |=> r_out_valid)
        else $error("executed request produced no response");

endmodule
